// ----- src/wtse_pkg.sv -----
// wtse_pkg: shared widths, constants and types of the wheel tick speed estimator
// used by wtse_divider and wheel_tick_speed_estimator_unit; no dependencies
`default_nettype none

package wtse_pkg;

    localparam int TIME_WIDTH      = 32;
    localparam int SPEED_WIDTH     = 16;
    localparam int CFG_WIDTH       = 16;
    localparam int CFG_IDX_WIDTH   = 1;
    localparam int NOW_WIDTH       = 32;
    localparam int OUT_SPEED_WIDTH = 16;
    localparam int STATUS_WIDTH    = 3;

    localparam int MUL_A_WIDTH = (SPEED_WIDTH > CFG_WIDTH) ? SPEED_WIDTH : CFG_WIDTH;
    localparam int PROD_WIDTH  = MUL_A_WIDTH + TIME_WIDTH;
    localparam int CNT_WIDTH   = $clog2(PROD_WIDTH);

    localparam logic [CFG_WIDTH-1:0] CIRC_RESET = CFG_WIDTH'(1000);
    localparam logic [CFG_WIDTH-1:0] GAP_RESET  = CFG_WIDTH'(3000);
    localparam logic [TIME_WIDTH-1:0] MS_PER_S  = TIME_WIDTH'(1000);
    localparam logic [SPEED_WIDTH-1:0] SPEED_MAX = {SPEED_WIDTH{1'b1}};

    localparam logic [CFG_IDX_WIDTH-1:0] REG_CIRCUMFERENCE = 1'b0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_MAX_GAP       = 1'b1;

    localparam logic OP_TICK   = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    typedef enum logic [STATUS_WIDTH-1:0] {
        ST_NO_HISTORY   = 3'd0,
        ST_NEW_INTERVAL = 3'd1,
        ST_HELD         = 3'd2,
        ST_EXTRAPOLATED = 3'd3,
        ST_TIMED_OUT    = 3'd4
    } t_status;

    typedef struct packed {
        logic                  start;
        logic [PROD_WIDTH-1:0] dividend;
        logic [TIME_WIDTH-1:0] divisor;
    } t_div_req;

endpackage

`default_nettype wire

// ----- src/wtse_divider.sv -----
// wtse_divider: restoring serial divider, one quotient bit per cycle
// depends on wtse_pkg
`default_nettype none

module wtse_divider (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire wtse_pkg::t_div_req            i_req,
    output logic                               o_done,
    output logic [wtse_pkg::PROD_WIDTH-1:0]    o_quotient
);

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_state;

    t_state                              r_state, n_state;
    logic [wtse_pkg::TIME_WIDTH:0]       r_rem, n_rem;
    logic [wtse_pkg::PROD_WIDTH-1:0]     r_dq, n_dq;
    logic [wtse_pkg::TIME_WIDTH-1:0]     r_divisor, n_divisor;
    logic [wtse_pkg::CNT_WIDTH-1:0]      r_count, n_count;
    logic                                r_done, n_done;

    logic [wtse_pkg::TIME_WIDTH:0]       w_shifted;
    logic                                w_ge;

    assign w_shifted = {r_rem[wtse_pkg::TIME_WIDTH-1:0], r_dq[wtse_pkg::PROD_WIDTH-1]};
    assign w_ge      = (w_shifted >= {1'b0, r_divisor});

    always_comb begin
        n_state   = r_state;
        n_rem     = r_rem;
        n_dq      = r_dq;
        n_divisor = r_divisor;
        n_count   = r_count;
        n_done    = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_req.start) begin
                    n_rem     = '0;
                    n_dq      = i_req.dividend;
                    n_divisor = i_req.divisor;
                    n_count   = wtse_pkg::CNT_WIDTH'(wtse_pkg::PROD_WIDTH - 1);
                    n_state   = S_RUN;
                end
            end
            S_RUN: begin
                n_rem = w_ge ? (w_shifted - {1'b0, r_divisor}) : w_shifted;
                n_dq  = {r_dq[wtse_pkg::PROD_WIDTH-2:0], w_ge};
                if (r_count == '0) begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_count = r_count - 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_rem     <= '0;
            r_dq      <= '0;
            r_divisor <= '0;
            r_count   <= '0;
            r_done    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rem     <= n_rem;
            r_dq      <= n_dq;
            r_divisor <= n_divisor;
            r_count   <= n_count;
            r_done    <= n_done;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_dq;

endmodule

`default_nettype wire

// ----- src/wheel_tick_speed_estimator_unit.sv -----
// wheel_tick_speed_estimator_unit: top level, sequencer, state and one shared multiplier
// depends on wtse_pkg and wtse_divider
// a tick word is stored from idle; an update word without division goes via S_DONE
// with division it runs S_MUL, S_DIV_GO and S_DIV_WAIT (48-step serial divider), then S_DONE
// one word is worked at a time; the input stalls until the result sits in the output register
// synchronous active-low reset: times and speeds cleared, circumference 1000, gap 3000
`default_nettype none

module wheel_tick_speed_estimator_unit (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_in_valid,
    output logic                                        o_in_stall,
    input  wire logic                                   i_operation,
    input  wire logic [wtse_pkg::NOW_WIDTH-1:0]         i_now_ms,
    output logic                                        o_out_valid,
    input  wire logic                                   i_out_stall,
    output logic [wtse_pkg::OUT_SPEED_WIDTH-1:0]        o_speed_mm_per_s,
    output logic [wtse_pkg::STATUS_WIDTH-1:0]           o_status,
    input  wire logic                                   i_cfg_valid,
    output logic                                        o_cfg_ready,
    input  wire logic [wtse_pkg::CFG_IDX_WIDTH-1:0]     i_cfg_index,
    input  wire logic [wtse_pkg::CFG_WIDTH-1:0]         i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DIV_GO,
        S_DIV_WAIT,
        S_DONE
    } t_state;

    localparam int TW = wtse_pkg::TIME_WIDTH;
    localparam int SW = wtse_pkg::SPEED_WIDTH;
    localparam int PW = wtse_pkg::PROD_WIDTH;

    t_state                                 r_state, n_state;
    logic [wtse_pkg::CFG_WIDTH-1:0]         r_circ, n_circ;
    logic [wtse_pkg::CFG_WIDTH-1:0]         r_max_gap, n_max_gap;
    logic [TW-1:0]                          r_newest, n_newest;
    logic [TW-1:0]                          r_previous, n_previous;
    logic [TW-1:0]                          r_used_newest, n_used_newest;
    logic [TW-1:0]                          r_used_previous, n_used_previous;
    logic [SW-1:0]                          r_speed_now, n_speed_now;
    logic [SW-1:0]                          r_speed_before, n_speed_before;
    logic                                   r_first, n_first;
    logic                                   r_extrap, n_extrap;
    wtse_pkg::t_status                      r_res_status, n_res_status;
    logic [wtse_pkg::MUL_A_WIDTH-1:0]       r_mul_a, n_mul_a;
    logic [TW-1:0]                          r_mul_b, n_mul_b;
    logic [PW-1:0]                          r_prod, n_prod;
    logic [TW-1:0]                          r_divisor, n_divisor;
    logic                                   r_out_valid, n_out_valid;
    logic [wtse_pkg::OUT_SPEED_WIDTH-1:0]   r_out_speed, n_out_speed;
    wtse_pkg::t_status                      r_out_status, n_out_status;

    logic [TW-1:0]          w_now;
    logic [TW-1:0]          w_gap;
    logic [TW-1:0]          w_span;
    logic [TW-1:0]          w_interval;
    logic [SW-1:0]          w_drop_base;
    logic                   w_in_acc;
    logic                   w_over_gap;
    logic                   w_over_twice;
    wtse_pkg::t_div_req     w_div_req;
    logic                   w_div_done;
    logic [PW-1:0]          w_quot;
    logic                   w_quot_hi;
    logic [SW-1:0]          w_quot_lo;

    assign w_now        = TW'(i_now_ms);
    assign w_gap        = w_now - r_used_newest;
    assign w_span       = r_used_newest - r_used_previous;
    assign w_interval   = r_newest - r_previous;
    assign w_drop_base  = r_speed_before - r_speed_now;
    assign w_in_acc     = i_in_valid && (r_state == S_IDLE);
    assign w_over_gap   = ({1'b0, w_gap} > (TW + 1)'(r_max_gap));
    assign w_over_twice = ({1'b0, w_gap} > (TW + 1)'({r_max_gap, 1'b0}));

    assign w_div_req.start    = (r_state == S_DIV_GO);
    assign w_div_req.dividend = r_prod;
    assign w_div_req.divisor  = r_divisor;

    assign w_quot_hi = |w_quot[PW-1:SW];
    assign w_quot_lo = w_quot[SW-1:0];

    wtse_divider u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_div_req),
        .o_done     (w_div_done),
        .o_quotient (w_quot)
    );

    always_comb begin
        n_state         = r_state;
        n_circ          = r_circ;
        n_max_gap       = r_max_gap;
        n_newest        = r_newest;
        n_previous      = r_previous;
        n_used_newest   = r_used_newest;
        n_used_previous = r_used_previous;
        n_speed_now     = r_speed_now;
        n_speed_before  = r_speed_before;
        n_first         = r_first;
        n_extrap        = r_extrap;
        n_res_status    = r_res_status;
        n_mul_a         = r_mul_a;
        n_mul_b         = r_mul_b;
        n_prod          = r_prod;
        n_divisor       = r_divisor;
        n_out_valid     = r_out_valid && i_out_stall;
        n_out_speed     = r_out_speed;
        n_out_status    = r_out_status;

        if (i_cfg_valid) begin
            case (i_cfg_index)
                wtse_pkg::REG_CIRCUMFERENCE: n_circ    = i_cfg_data;
                wtse_pkg::REG_MAX_GAP:       n_max_gap = i_cfg_data;
                default: begin
                end
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (w_in_acc && (i_operation == wtse_pkg::OP_TICK)) begin
                    n_previous = r_newest;
                    n_newest   = w_now;
                end else if (w_in_acc) begin
                    n_state = S_DONE;
                    if (r_previous == '0) begin
                        n_speed_now  = '0;
                        n_res_status = wtse_pkg::ST_NO_HISTORY;
                    end else if ((r_used_newest == '0) || (r_used_previous != r_previous)) begin
                        n_first       = (r_used_newest == '0);
                        n_extrap      = 1'b0;
                        n_res_status  = wtse_pkg::ST_NEW_INTERVAL;
                        n_used_newest = r_newest;
                        if (r_used_newest == '0) begin
                            n_used_previous = r_previous;
                        end else begin
                            n_used_previous = r_used_newest;
                            n_speed_before  = r_speed_now;
                        end
                        if (w_interval == '0) begin
                            n_speed_now = wtse_pkg::SPEED_MAX;
                            if (r_used_newest == '0) begin
                                n_speed_before = wtse_pkg::SPEED_MAX;
                            end
                        end else begin
                            n_mul_a   = wtse_pkg::MUL_A_WIDTH'(r_circ);
                            n_mul_b   = wtse_pkg::MS_PER_S;
                            n_divisor = w_interval;
                            n_state   = S_MUL;
                        end
                    end else if (w_over_gap) begin
                        n_speed_now  = '0;
                        n_res_status = wtse_pkg::ST_TIMED_OUT;
                        if (w_over_twice) begin
                            n_speed_before = '0;
                            n_previous     = '0;
                        end
                    end else if (r_speed_before > r_speed_now) begin
                        n_res_status = wtse_pkg::ST_EXTRAPOLATED;
                        if (w_span == '0) begin
                            n_speed_now = '0;
                        end else begin
                            n_first   = 1'b0;
                            n_extrap  = 1'b1;
                            n_mul_a   = wtse_pkg::MUL_A_WIDTH'(w_drop_base);
                            n_mul_b   = w_gap;
                            n_divisor = w_span;
                            n_state   = S_MUL;
                        end
                    end else begin
                        n_res_status = wtse_pkg::ST_HELD;
                    end
                end
            end
            S_MUL: begin
                n_prod  = PW'(r_mul_a) * PW'(r_mul_b);
                n_state = S_DIV_GO;
            end
            S_DIV_GO: begin
                n_state = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (w_div_done) begin
                    n_state = S_DONE;
                    if (r_extrap) begin
                        if (w_quot_hi || (w_quot_lo >= r_speed_now)) begin
                            n_speed_now = '0;
                        end else begin
                            n_speed_now = r_speed_now - w_quot_lo;
                        end
                    end else begin
                        n_speed_now = w_quot_hi ? wtse_pkg::SPEED_MAX : w_quot_lo;
                        if (r_first) begin
                            n_speed_before = w_quot_hi ? wtse_pkg::SPEED_MAX : w_quot_lo;
                        end
                    end
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid  = 1'b1;
                    n_out_speed  = wtse_pkg::OUT_SPEED_WIDTH'(r_speed_now);
                    n_out_status = r_res_status;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_circ          <= wtse_pkg::CIRC_RESET;
            r_max_gap       <= wtse_pkg::GAP_RESET;
            r_newest        <= '0;
            r_previous      <= '0;
            r_used_newest   <= '0;
            r_used_previous <= '0;
            r_speed_now     <= '0;
            r_speed_before  <= '0;
            r_first         <= 1'b0;
            r_extrap        <= 1'b0;
            r_res_status    <= wtse_pkg::ST_NO_HISTORY;
            r_out_valid     <= 1'b0;
            r_out_status    <= wtse_pkg::ST_NO_HISTORY;
        end else begin
            r_state         <= n_state;
            r_circ          <= n_circ;
            r_max_gap       <= n_max_gap;
            r_newest        <= n_newest;
            r_previous      <= n_previous;
            r_used_newest   <= n_used_newest;
            r_used_previous <= n_used_previous;
            r_speed_now     <= n_speed_now;
            r_speed_before  <= n_speed_before;
            r_first         <= n_first;
            r_extrap        <= n_extrap;
            r_res_status    <= n_res_status;
            r_out_valid     <= n_out_valid;
            r_out_status    <= n_out_status;
        end
        r_mul_a     <= n_mul_a;
        r_mul_b     <= n_mul_b;
        r_prod      <= n_prod;
        r_divisor   <= n_divisor;
        r_out_speed <= n_out_speed;
    end

    assign o_in_stall       = (r_state != S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_speed_mm_per_s = r_out_speed;
    assign o_status         = r_out_status;
    assign o_cfg_ready      = 1'b1;

endmodule

`default_nettype wire

// ----- verif/wheel_tick_speed_estimator_unit_tb.sv -----
`timescale 1ns / 1ps
// wheel_tick_speed_estimator_unit_tb: self-checking bench, directed script then random words
// depends on wtse_pkg and wheel_tick_speed_estimator_unit; speed words checked against an in-line predictor

module wheel_tick_speed_estimator_unit_tb;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 64;
    localparam int PHASE_WORDS    = 200;
    localparam int HOLD_CYCLES    = 400;
    localparam int SCRIPT_ROWS    = 23;

    typedef struct packed {
        logic [wtse_pkg::OUT_SPEED_WIDTH-1:0] speed;
        wtse_pkg::t_status                    status;
    } t_speed_word;

    typedef struct packed {
        logic                                 op;
        logic [wtse_pkg::NOW_WIDTH-1:0]       now;
        logic                                 typed;
        logic [wtse_pkg::OUT_SPEED_WIDTH-1:0] speed;
        wtse_pkg::t_status                    status;
    } t_script_row;

    logic                                 i_clk;
    logic                                 i_rst_n     = 1'b0;
    logic                                 i_in_valid  = 1'b0;
    logic                                 i_operation = wtse_pkg::OP_TICK;
    logic [wtse_pkg::NOW_WIDTH-1:0]       i_now_ms    = '0;
    logic                                 i_out_stall = 1'b0;
    logic                                 i_cfg_valid = 1'b0;
    logic [wtse_pkg::CFG_IDX_WIDTH-1:0]   i_cfg_index = wtse_pkg::REG_CIRCUMFERENCE;
    logic [wtse_pkg::CFG_WIDTH-1:0]       i_cfg_data  = '0;
    logic                                 o_in_stall;
    logic                                 o_out_valid;
    logic [wtse_pkg::OUT_SPEED_WIDTH-1:0] o_speed_mm_per_s;
    logic [wtse_pkg::STATUS_WIDTH-1:0]    o_status;
    logic                                 o_cfg_ready;

    // predictor state
    logic [wtse_pkg::CFG_WIDTH-1:0]   circ_mm  = wtse_pkg::CIRC_RESET;
    logic [wtse_pkg::CFG_WIDTH-1:0]   gap_ms   = wtse_pkg::GAP_RESET;
    logic [wtse_pkg::TIME_WIDTH-1:0]  tick_new = '0;
    logic [wtse_pkg::TIME_WIDTH-1:0]  tick_old = '0;
    logic [wtse_pkg::TIME_WIDTH-1:0]  used_new = '0;
    logic [wtse_pkg::TIME_WIDTH-1:0]  used_old = '0;
    logic [wtse_pkg::SPEED_WIDTH-1:0] spd_now  = '0;
    logic [wtse_pkg::SPEED_WIDTH-1:0] spd_prev = '0;

    t_speed_word speed_expected[$];
    int          failures      = 0;
    int          quiet_cycles  = 0;
    int          send_idle_pct = 0;
    int          stall_pct     = 0;
    bit          pressure_on   = 1'b0;
    logic        long_hold     = 1'b0;

    wheel_tick_speed_estimator_unit DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_operation      (i_operation),
        .i_now_ms         (i_now_ms),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_speed_mm_per_s (o_speed_mm_per_s),
        .o_status         (o_status),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [wtse_pkg::SPEED_WIDTH-1:0] rate_from_ticks();
        logic [wtse_pkg::TIME_WIDTH-1:0] interval;
        logic [63:0]                     quotient;
        interval = tick_new - tick_old;
        if (interval == 0) return wtse_pkg::SPEED_MAX;
        quotient = (64'(circ_mm) * 64'd1000) / 64'(interval);
        return (quotient > 64'(wtse_pkg::SPEED_MAX)) ? wtse_pkg::SPEED_MAX
                                                     : wtse_pkg::SPEED_WIDTH'(quotient);
    endfunction

    function automatic logic [wtse_pkg::SPEED_WIDTH-1:0] decayed_speed(
            input logic [wtse_pkg::TIME_WIDTH-1:0] now);
        logic [wtse_pkg::TIME_WIDTH-1:0] span;
        logic [wtse_pkg::TIME_WIDTH-1:0] since;
        logic [63:0]                     drop;
        span  = used_new - used_old;
        since = now - used_new;
        if (span == 0) return '0;
        drop = (64'(spd_prev - spd_now) * 64'(since)) / 64'(span);
        return (drop >= 64'(spd_now)) ? '0 : spd_now - wtse_pkg::SPEED_WIDTH'(drop);
    endfunction

    function automatic void apply_word(input logic op,
                                       input logic [wtse_pkg::NOW_WIDTH-1:0] now_in,
                                       output logic has_word, output t_speed_word word);
        logic [wtse_pkg::TIME_WIDTH-1:0] now;
        logic [wtse_pkg::TIME_WIDTH-1:0] since;
        now      = wtse_pkg::TIME_WIDTH'(now_in);
        has_word = 1'b0;
        word     = '0;
        if (op == wtse_pkg::OP_TICK) begin
            tick_old = tick_new;
            tick_new = now;
            return;
        end
        has_word = 1'b1;
        if (tick_old == 0) begin
            spd_now     = '0;
            word.status = wtse_pkg::ST_NO_HISTORY;
        end else if (used_new == 0) begin
            spd_now     = rate_from_ticks();
            spd_prev    = spd_now;
            used_old    = tick_old;
            used_new    = tick_new;
            word.status = wtse_pkg::ST_NEW_INTERVAL;
        end else if (used_old == tick_old) begin
            since = now - used_new;
            if (64'(since) > 64'(gap_ms)) begin
                spd_now = '0;
                // long silence also forgets the tick history
                if (64'(since) > 2 * 64'(gap_ms)) begin
                    spd_prev = '0;
                    tick_old = '0;
                end
                word.status = wtse_pkg::ST_TIMED_OUT;
            end else if (spd_prev > spd_now) begin
                spd_now     = decayed_speed(now);
                word.status = wtse_pkg::ST_EXTRAPOLATED;
            end else begin
                word.status = wtse_pkg::ST_HELD;
            end
        end else begin
            used_old    = used_new;
            used_new    = tick_new;
            spd_prev    = spd_now;
            spd_now     = rate_from_ticks();
            word.status = wtse_pkg::ST_NEW_INTERVAL;
        end
        word.speed = wtse_pkg::OUT_SPEED_WIDTH'(spd_now);
    endfunction

    task automatic send_word(input logic op, input logic [wtse_pkg::NOW_WIDTH-1:0] now,
                             input logic typed, input t_speed_word typed_word);
        logic        has_word;
        t_speed_word word;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_now_ms    <= now;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        apply_word(op, now, has_word, word);
        if (has_word) speed_expected.push_back(typed ? typed_word : word);
    endtask

    task automatic drain_words();
        i_in_valid <= 1'b0;
        while (speed_expected.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [wtse_pkg::CFG_IDX_WIDTH-1:0] idx,
                             input logic [wtse_pkg::CFG_WIDTH-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == wtse_pkg::REG_CIRCUMFERENCE) circ_mm = data;
        else gap_ms = data;
    endtask

    task automatic set_wheel(input logic [wtse_pkg::CFG_WIDTH-1:0] circ,
                             input logic [wtse_pkg::CFG_WIDTH-1:0] gap);
        drain_words();
        write_reg(wtse_pkg::REG_CIRCUMFERENCE, circ);
        write_reg(wtse_pkg::REG_MAX_GAP, gap);
        i_cfg_valid <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        i_out_stall <= long_hold || ($urandom_range(99) < stall_pct);
    end

    initial begin : hold_off
        wait (pressure_on);
        @(posedge i_clk);
        long_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        long_hold <= 1'b0;
    end

    always @(posedge i_clk) begin : check_words
        t_speed_word want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (speed_expected.size() == 0) begin
                    $display("%0t unexpected word: speed %0d status %0d",
                             $time, o_speed_mm_per_s, o_status);
                    failures++;
                end else begin
                    want = speed_expected.pop_front();
                    if (o_speed_mm_per_s !== want.speed) begin
                        $display("%0t speed: expected %0d, actual %0d",
                                 $time, want.speed, o_speed_mm_per_s);
                        failures++;
                    end
                    if (o_status !== want.status) begin
                        $display("%0t status: expected %0d, actual %0d",
                                 $time, want.status, o_status);
                        failures++;
                    end
                end
            end
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                    || (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin : watchdog
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("wheel_tick_speed_estimator_unit: mismatch");
        $finish;
    end

    initial begin : stimulus
        t_script_row                    script [SCRIPT_ROWS];
        logic [wtse_pkg::NOW_WIDTH-1:0] clock_ms;
        logic [wtse_pkg::NOW_WIDTH-1:0] now;
        int unsigned                    gap_span;
        int unsigned                    step;
        int unsigned                    pick;
        int                             phase;
        int                             n;
        script = '{
            '{wtse_pkg::OP_UPDATE, 32'd5,         1'b1, 16'd0,
              wtse_pkg::ST_NO_HISTORY},
            '{wtse_pkg::OP_TICK,   32'd1,         1'b0, 16'd0,
              wtse_pkg::ST_NO_HISTORY},
            '{wtse_pkg::OP_UPDATE, 32'd2,         1'b1, 16'd0,
              wtse_pkg::ST_NO_HISTORY},
            '{wtse_pkg::OP_TICK,   32'd1,         1'b0, 16'd0,
              wtse_pkg::ST_NO_HISTORY},
            '{wtse_pkg::OP_UPDATE, 32'd1,         1'b1, wtse_pkg::SPEED_MAX,
              wtse_pkg::ST_NEW_INTERVAL},
            '{wtse_pkg::OP_UPDATE, 32'd1,         1'b1, wtse_pkg::SPEED_MAX,
              wtse_pkg::ST_HELD},
            '{wtse_pkg::OP_UPDATE, 32'hFFFF_FFFF, 1'b1, 16'd0,
              wtse_pkg::ST_TIMED_OUT},
            '{wtse_pkg::OP_UPDATE, 32'd0,         1'b1, 16'd0,
              wtse_pkg::ST_NO_HISTORY},
            '{wtse_pkg::OP_TICK,   32'd100,       1'b0, 16'd0,
              wtse_pkg::ST_NO_HISTORY},
            '{wtse_pkg::OP_TICK,   32'd200,       1'b0, 16'd0,
              wtse_pkg::ST_NO_HISTORY},
            '{wtse_pkg::OP_UPDATE, 32'd250,       1'b0, 16'd0,
              wtse_pkg::ST_NO_HISTORY},
            '{wtse_pkg::OP_TICK,   32'd700,       1'b0, 16'd0,
              wtse_pkg::ST_NO_HISTORY},
            '{wtse_pkg::OP_UPDATE, 32'd710,       1'b0, 16'd0,
              wtse_pkg::ST_NO_HISTORY},
            '{wtse_pkg::OP_UPDATE, 32'd750,       1'b0, 16'd0,
              wtse_pkg::ST_NO_HISTORY},
            '{wtse_pkg::OP_UPDATE, 32'd800,       1'b0, 16'd0,
              wtse_pkg::ST_NO_HISTORY},
            '{wtse_pkg::OP_UPDATE, 32'd3700,      1'b0, 16'd0,
              wtse_pkg::ST_NO_HISTORY},
            '{wtse_pkg::OP_UPDATE, 32'd3701,      1'b0, 16'd0,
              wtse_pkg::ST_NO_HISTORY},
            '{wtse_pkg::OP_TICK,   32'hFFFF_FFF0, 1'b0, 16'd0,
              wtse_pkg::ST_NO_HISTORY},
            '{wtse_pkg::OP_TICK,   32'h0000_0010, 1'b0, 16'd0,
              wtse_pkg::ST_NO_HISTORY},
            '{wtse_pkg::OP_UPDATE, 32'h0000_0020, 1'b0, 16'd0,
              wtse_pkg::ST_NO_HISTORY},
            '{wtse_pkg::OP_TICK,   32'd0,         1'b0, 16'd0,
              wtse_pkg::ST_NO_HISTORY},
            '{wtse_pkg::OP_TICK,   32'h0000_0030, 1'b0, 16'd0,
              wtse_pkg::ST_NO_HISTORY},
            '{wtse_pkg::OP_UPDATE, 32'h0000_0040, 1'b1, 16'd0,
              wtse_pkg::ST_NO_HISTORY}
        };

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (script[k]) begin
            send_word(script[k].op, script[k].now, script[k].typed,
                      t_speed_word'{script[k].speed, script[k].status});
        end

        for (phase = 0; phase < 5; phase++) begin
            clock_ms = $urandom();
            case (phase)
                0: begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1: begin
                    set_wheel(16'hFFFF, 16'd1);
                    send_idle_pct = 72;
                    stall_pct     = 0;
                end
                2: begin
                    set_wheel(16'd1, 16'hFFFF);
                    send_idle_pct = 0;
                    stall_pct     = 72;
                end
                3: begin
                    set_wheel(wtse_pkg::CFG_WIDTH'($urandom_range(65535, 1)),
                              wtse_pkg::CFG_WIDTH'($urandom_range(65535, 1)));
                    send_idle_pct = 27;
                    stall_pct     = 27;
                    // cross the time wrap
                    clock_ms      = 32'hFFFF_F000;
                end
                default: begin
                    set_wheel(wtse_pkg::CFG_WIDTH'($urandom_range(65535, 1)),
                              wtse_pkg::CFG_WIDTH'($urandom_range(2000, 50)));
                    send_idle_pct = 0;
                    stall_pct     = 0;
                    pressure_on   = 1'b1;
                end
            endcase
            gap_span = 32'(gap_ms);
            for (n = 0; n < PHASE_WORDS; n++) begin
                pick = $urandom_range(99);
                if (pick < 4) begin
                    now = $urandom();
                end else if (pick < 6) begin
                    now = '0;
                end else begin
                    pick = $urandom_range(99);
                    if (pick < 70) step = $urandom_range(gap_span / 4 + 3, 0);
                    else if (pick < 85) step = $urandom_range(gap_span + 2, gap_span / 2);
                    else if (pick < 95) step = $urandom_range(2 * gap_span + 2, gap_span);
                    else step = $urandom_range(65535, 0);
                    clock_ms = clock_ms + step;
                    now      = clock_ms;
                end
                send_word(($urandom_range(99) < 45) ? wtse_pkg::OP_TICK : wtse_pkg::OP_UPDATE,
                          now, 1'b0, '0);
            end
        end

        drain_words();
        if (failures == 0) begin
            $display("wheel_tick_speed_estimator_unit: match");
        end else begin
            $display("wheel_tick_speed_estimator_unit: mismatch");
        end
        $finish;
    end

endmodule
